// ===== rtl/frs_pkg.sv =====
// shared constants, codes and types for the fragment reassembly block
package frs_pkg;

	localparam int unsigned SLOTS      = 4;
	localparam int unsigned MAX_PACKET = 4096;

	localparam int unsigned SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned OFS_W   = $clog2(MAX_PACKET);
	localparam int unsigned ADDR_W  = SLOT_W + OFS_W;
	localparam int unsigned DEPTH   = SLOTS * MAX_PACKET;
	localparam int unsigned POS_W   = 17;

	// input kinds
	localparam logic KIND_FRAG = 1'b0;
	localparam logic KIND_READ = 1'b1;

	// result status codes
	localparam logic [2:0] ST_OK           = 3'd0;
	localparam logic [2:0] ST_LEN_MISMATCH = 3'd1;
	localparam logic [2:0] ST_OOB          = 3'd2;
	localparam logic [2:0] ST_TOO_BIG      = 3'd3;
	localparam logic [2:0] ST_COMPLETE     = 3'd4;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PKT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RX_BUF  = 1'd1;

	localparam logic [12:0] MAX_PKT_RST = 13'd4096;
	localparam logic [15:0] RX_BUF_RST  = 16'd4096;

	typedef struct packed {
		logic [2:0]        status;
		logic [SLOT_W-1:0] slot;
		logic [15:0]       packet_bytes;
	} frag_res_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} store_wr_t;

endpackage

// ===== rtl/fragment_reassembly_slots_core.sv =====
// top level of the fragment reassembly block
//
// usage: fragment payload bytes (kind 0) and store reads (kind 1) enter on
// the input channel, in_valid with in_stall; one result leaves per request on
// the output channel, out_valid with out_stall. every field is its own port.
// on the first byte of a fragment the tag is matched against live slots, a
// miss claims the next slot round robin; bytes land in a 16k x 8 packet store.
// one request per cycle is sustained while out_stall is low: each byte does one
// tag match, one count update and one store access, and a read's data comes
// from the store's registered read port. the result register takes a new
// request in the same cycle as the old one leaves; in_stall rises only while
// a result is held and out_stall is high. configuration (max_packet_bytes
// index 0, receive_buffer_bytes index 1) is for the user to write through
// cfg_we / cfg_index / cfg_data only while no request is in flight; the block
// does not check. reset clears slots, counts and pointers and restores both
// registers to 4096; the store is not cleared, so unwritten bytes read undefined.
module fragment_reassembly_slots_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [frs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [15:0]                     cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            kind,
	input  logic [31:0]                     tag,
	input  logic [15:0]                     frag_offset,
	input  logic [15:0]                     frag_total,
	input  logic [15:0]                     frag_length,
	input  logic [15:0]                     packet_length,
	input  logic [15:0]                     payload_received,
	input  logic [15:0]                     byte_index,
	input  logic [7:0]                      data_byte,
	input  logic                            last_byte,
	input  logic [1:0]                      read_slot,
	input  logic [11:0]                     read_offset,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [2:0]                      status,
	output logic [1:0]                      slot_index,
	output logic [15:0]                     packet_bytes,
	output logic [7:0]                      read_byte
);

	logic [12:0]                max_pkt_q;
	logic [15:0]                rx_buf_q;
	logic                       acc;
	logic                       rd_ok;
	logic                       rd_en;
	logic [frs_pkg::ADDR_W-1:0] rd_addr;
	logic [7:0]                 rd_data;
	frs_pkg::frag_res_t         res;
	frs_pkg::store_wr_t         wr;

	logic                       valid_s1;
	logic                       rd_ok_s1;
	logic [2:0]                 status_s1;
	logic [1:0]                 slot_s1;
	logic [15:0]                pbytes_s1;

	assign in_stall = valid_s1 && out_stall;
	assign acc      = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_pkt_q <= frs_pkg::MAX_PKT_RST;
			rx_buf_q  <= frs_pkg::RX_BUF_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				frs_pkg::CFG_MAX_PKT: max_pkt_q <= cfg_data[12:0];
				frs_pkg::CFG_RX_BUF:  rx_buf_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	frs_slot_ctrl u_slot_ctrl (
		.clk                  (clk),
		.arst_n               (arst_n),
		.acc                  (acc),
		.kind                 (kind),
		.tag                  (tag),
		.frag_offset          (frag_offset),
		.frag_total           (frag_total),
		.frag_length          (frag_length),
		.packet_length        (packet_length),
		.payload_received     (payload_received),
		.byte_index           (byte_index),
		.data_byte            (data_byte),
		.last_byte            (last_byte),
		.max_packet_bytes     (max_pkt_q),
		.receive_buffer_bytes (rx_buf_q),
		.res                  (res),
		.wr                   (wr)
	);

	// reads outside the slot range or the MAX_PACKET slot size return zero
	assign rd_ok = (kind == frs_pkg::KIND_READ)
		&& ({30'd0, read_slot} < frs_pkg::SLOTS)
		&& ({20'd0, read_offset} < frs_pkg::MAX_PACKET);
	assign rd_en   = acc && rd_ok;
	assign rd_addr = {frs_pkg::SLOT_W'(read_slot), frs_pkg::OFS_W'(read_offset)};

	frs_ram #(
		.WIDTH (8),
		.DEPTH (frs_pkg::DEPTH)
	) u_store (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_ok_s1  <= rd_ok;
			status_s1 <= res.status;
			slot_s1   <= (kind == frs_pkg::KIND_READ) ? read_slot : 2'(res.slot);
			pbytes_s1 <= res.packet_bytes;
		end
	end

	// store read data holds while stalled since the read port only fires on a request
	assign out_valid    = valid_s1;
	assign status       = status_s1;
	assign slot_index   = slot_s1;
	assign packet_bytes = pbytes_s1;
	assign read_byte    = rd_ok_s1 ? rd_data : 8'd0;

endmodule

// ===== rtl/frs_ram.sv =====
// generic simple dual-port ram with registered read
module frs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/frs_slot_ctrl.sv =====
// slot table: tag match, round-robin claim, fragment counts and store write
module frs_slot_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    acc,
	input  logic                    kind,
	input  logic [31:0]             tag,
	input  logic [15:0]             frag_offset,
	input  logic [15:0]             frag_total,
	input  logic [15:0]             frag_length,
	input  logic [15:0]             packet_length,
	input  logic [15:0]             payload_received,
	input  logic [15:0]             byte_index,
	input  logic [7:0]              data_byte,
	input  logic                    last_byte,
	input  logic [12:0]             max_packet_bytes,
	input  logic [15:0]             receive_buffer_bytes,
	output frs_pkg::frag_res_t      res,
	output frs_pkg::store_wr_t      wr
);

	logic [31:0]                 slot_tag_q   [frs_pkg::SLOTS];
	logic [frs_pkg::SLOTS-1:0]   slot_valid_q;
	logic [15:0]                 slot_count_q [frs_pkg::SLOTS];
	logic [frs_pkg::SLOT_W-1:0]  next_slot_q;
	logic [frs_pkg::SLOT_W-1:0]  cur_slot_q;

	logic                        hit;
	logic [frs_pkg::SLOT_W-1:0]  hit_idx;
	logic [frs_pkg::SLOT_W-1:0]  nxt;
	logic [frs_pkg::SLOT_W-1:0]  slot;
	logic                        first;
	logic                        frag_ok;
	logic                        claim;
	logic [frs_pkg::POS_W-1:0]   bound;
	logic [frs_pkg::POS_W-1:0]   pos;
	logic [frs_pkg::POS_W-1:0]   frag_end;
	logic                        oob;
	logic                        bump;
	logic [15:0]                 cnt_old;
	logic [15:0]                 cnt_new;
	logic                        done;

	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		// walk downwards so the lowest matching slot wins
		for (int s = frs_pkg::SLOTS - 1; s >= 0; s--) begin
			if (slot_valid_q[s] && slot_tag_q[s] == tag) begin
				hit     = 1'b1;
				hit_idx = frs_pkg::SLOT_W'(s);
			end
		end

		nxt = (next_slot_q == frs_pkg::SLOT_W'(frs_pkg::SLOTS - 1)) ? '0
			: next_slot_q + 1'b1;

		first   = (byte_index == 16'd0);
		frag_ok = (kind == frs_pkg::KIND_FRAG) && (frag_length == payload_received);
		claim   = first && !hit;
		slot    = first ? (hit ? hit_idx : nxt) : cur_slot_q;

		bound = ({4'd0, max_packet_bytes} > frs_pkg::POS_W'(frs_pkg::MAX_PACKET))
			? frs_pkg::POS_W'(frs_pkg::MAX_PACKET) : {4'd0, max_packet_bytes};
		frag_end = {1'b0, frag_offset} + {1'b0, frag_length};
		pos      = {1'b0, frag_offset} + {1'b0, byte_index};
		oob      = frag_end > bound;

		// a freshly claimed slot starts from an empty count
		cnt_old = claim ? 16'd0 : slot_count_q[slot];
		cnt_new = (cnt_old != 16'hFFFF) ? cnt_old + 16'd1 : cnt_old;
		bump    = !oob && last_byte;
		done    = bump && (cnt_new >= frag_total);

		res.slot         = frag_ok ? slot : '0;
		res.packet_bytes = 16'd0;
		if (kind == frs_pkg::KIND_READ) begin
			res.status = frs_pkg::ST_OK;
		end else if (!frag_ok) begin
			res.status = frs_pkg::ST_LEN_MISMATCH;
		end else if (oob) begin
			res.status = frs_pkg::ST_OOB;
		end else if (done) begin
			if (packet_length > receive_buffer_bytes) begin
				res.status = frs_pkg::ST_TOO_BIG;
			end else begin
				res.status       = frs_pkg::ST_COMPLETE;
				res.packet_bytes = packet_length;
			end
		end else begin
			res.status = frs_pkg::ST_OK;
		end

		wr.en   = acc && frag_ok && !oob && (pos < bound);
		wr.addr = {slot, pos[frs_pkg::OFS_W-1:0]};
		wr.data = data_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			next_slot_q  <= '0;
			cur_slot_q   <= '0;
			for (int s = 0; s < frs_pkg::SLOTS; s++) begin
				slot_count_q[s] <= 16'd0;
			end
		end else if (acc && frag_ok) begin
			if (first) begin
				cur_slot_q <= slot;
			end
			if (claim) begin
				next_slot_q       <= nxt;
				slot_valid_q[nxt] <= 1'b1;
			end
			if (claim || bump) begin
				slot_count_q[slot] <= bump ? cnt_new : 16'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && frag_ok && claim) begin
			slot_tag_q[nxt] <= tag;
		end
	end

endmodule

// ===== rtl/frs_checker.sv =====
// port-level checks for the fragment reassembly block, bound to the top level
module frs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [1:0]  slot_index,
	input logic [15:0] packet_bytes,
	input logic [7:0]  read_byte
);

	// a held result keeps its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(packet_bytes)
			&& $stable(slot_index) && $stable(read_byte))
		else $error("result changed while stalled");

	// every accepted request shows a result in the next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("accepted request gave no result");

	// input back-pressure only comes from a held result
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held result");

	a_pbytes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != frs_pkg::ST_COMPLETE |-> packet_bytes == 16'd0)
		else $error("packet length reported without completion");

	a_mismatch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == frs_pkg::ST_LEN_MISMATCH |-> slot_index == 2'd0
			&& read_byte == 8'd0)
		else $error("length mismatch with slot or data");

endmodule

bind fragment_reassembly_slots_core frs_checker u_frs_checker (.*);
